// ===== hw/rtl/ivh_pkg.sv =====
`default_nettype none

package ivh_pkg;

  // Depth of the queue between the front and the back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Kind of work a queued beat asks of the back
  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,  // hash one byte, string continues
    OP_BYTE_LAST = 2'd1,  // hash one byte, then finish the string
    OP_END       = 2'd2   // no byte, finish the string
  } op_e;

  // Back sequencer states
  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_MIX  = 2'd1,
    ST_MUL1 = 2'd2,
    ST_MUL2 = 2'd3
  } state_e;

  // One queued beat
  typedef struct packed {
    op_e         op;
    logic [7:0]  song_byte;
    logic [31:0] id;
  } item_t;

  // Queue status seen by the front and the top
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } fifo_stat_t;

  // Back status
  typedef struct packed {
    state_e state;
    logic   pop;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ivh_front.sv =====
`default_nettype none

module ivh_front (
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          song_byte_i,
  input  wire logic                byte_valid_i,
  input  wire logic                last_i,
  input  wire logic [31:0]         id_i,
  input  wire ivh_pkg::fifo_stat_t q_stat_i,
  output logic                     push_o,
  output ivh_pkg::item_t           item_o
);

  logic accept;

  // Take a beat whenever the queue has room
  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the beat; drop beats that carry neither a byte nor an end
  always_comb begin
    item_o.song_byte = song_byte_i;
    item_o.id        = id_i;
    push_o           = 1'b0;
    item_o.op        = ivh_pkg::OP_BYTE;
    priority if (byte_valid_i && last_i) begin
      item_o.op = ivh_pkg::OP_BYTE_LAST;
      push_o    = accept;
    end else if (byte_valid_i) begin
      item_o.op = ivh_pkg::OP_BYTE;
      push_o    = accept;
    end else if (last_i) begin
      item_o.op = ivh_pkg::OP_END;
      push_o    = accept;
    end else begin
      push_o    = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ivh_fifo.sv =====
`default_nettype none

module ivh_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ivh_pkg::item_t item_i,
  input  wire logic           pop_i,
  output ivh_pkg::item_t      item_o,
  output ivh_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PW = ivh_pkg::QPTR_W;
  localparam int unsigned CW = ivh_pkg::QCNT_W;

  ivh_pkg::item_t mem_q [ivh_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push, do_pop;

  assign stat_o.full  = (count_q == CW'(ivh_pkg::QDEPTH));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;
  assign item_o       = mem_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(ivh_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(ivh_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ivh_back.sv =====
`default_nettype none

module ivh_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire ivh_pkg::item_t item_i,
  output logic                pop_o,
  output ivh_pkg::back_stat_t stat_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic signed [31:0]  code_o
);

  ivh_pkg::state_e state_q, state_d;

  logic [31:0] fwd_q, fwd_d;
  logic [31:0] rev_q, rev_d;
  logic [31:0] coef_q, coef_d;
  logic        par_q, par_d;
  logic [31:0] id_q, id_d;
  logic [31:0] opa_q, opa_d;
  logic [31:0] opb_q, opb_d;
  logic [31:0] opc_q, opc_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] code_q, code_d;
  logic        out_valid_q, out_valid_d;

  logic        has_byte, ends;
  logic [31:0] c_ext;
  logic [31:0] pb;
  logic [31:0] fwd_upd, rev_upd, coef_upd;
  logic [7:0]  mix_hi, mix_lo;
  logic [31:0] mix;
  logic        load_out;

  assign pop_o        = (state_q == ivh_pkg::ST_RUN) && !empty_i;
  assign stat_o.state = state_q;
  assign stat_o.pop   = pop_o;
  assign out_valid_o  = out_valid_q;
  assign code_o       = code_q;
  assign load_out     = (state_q == ivh_pkg::ST_MUL2) && (!out_valid_q || out_ready_i);

  // Decode the head beat
  always_comb begin
    has_byte = 1'b0;
    ends     = 1'b0;
    unique case (item_i.op)
      ivh_pkg::OP_BYTE:      begin has_byte = 1'b1; ends = 1'b0; end
      ivh_pkg::OP_BYTE_LAST: begin has_byte = 1'b1; ends = 1'b1; end
      ivh_pkg::OP_END:       begin has_byte = 1'b0; ends = 1'b1; end
      default:               begin has_byte = 1'b0; ends = 1'b0; end
    endcase
  end

  // Per-byte update: shift-add forward hash, 32x8 product for reverse hash
  assign c_ext    = {{24{item_i.song_byte[7]}}, item_i.song_byte};
  assign fwd_upd  = c_ext + (par_q ? ((fwd_q << 4) + fwd_q) : ((fwd_q << 3) + fwd_q));
  assign pb       = coef_q * {24'b0, item_i.song_byte};
  assign rev_upd  = rev_q + pb
                  - (item_i.song_byte[7] ? {coef_q[23:0], 8'b0} : 32'b0);
  assign coef_upd = par_q ? ((coef_q << 5) + coef_q) : ((coef_q << 4) + coef_q);

  // Rearrange id bytes into the mix word
  assign mix_hi = (id_q[23:16] == 8'h00) ? ~id_q[15:8] : id_q[23:16];
  assign mix_lo = (id_q[31:24] == 8'h00) ? ~id_q[7:0]  : id_q[31:24];
  assign mix    = {id_q[7:0], mix_hi, id_q[15:8], mix_lo};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ivh_pkg::ST_RUN:  if (pop_o && ends) state_d = ivh_pkg::ST_MIX;
      ivh_pkg::ST_MIX:  state_d = ivh_pkg::ST_MUL1;
      ivh_pkg::ST_MUL1: state_d = ivh_pkg::ST_MUL2;
      ivh_pkg::ST_MUL2: if (load_out) state_d = ivh_pkg::ST_RUN;
      default:          state_d = ivh_pkg::ST_RUN;
    endcase
  end

  // Datapath and output register
  always_comb begin
    fwd_d       = fwd_q;
    rev_d       = rev_q;
    coef_d      = coef_q;
    par_d       = par_q;
    id_d        = id_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    opc_d       = opc_q;
    prod_d      = prod_q;
    code_d      = code_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ivh_pkg::ST_RUN: begin
        if (pop_o && has_byte) begin
          fwd_d  = fwd_upd;
          rev_d  = rev_upd;
          coef_d = coef_upd;
          par_d  = !par_q;
        end
        if (pop_o && ends) begin
          id_d = item_i.id;
        end
      end
      ivh_pkg::ST_MIX: begin
        // Form mix operands, then clear the string state
        opa_d  = (rev_q ^ mix) + (fwd_q | id_q);
        opb_d  = fwd_q | mix;
        opc_d  = rev_q ^ id_q;
        fwd_d  = '0;
        rev_d  = '0;
        coef_d = 32'd1;
        par_d  = 1'b0;
      end
      ivh_pkg::ST_MUL1: begin
        prod_d = opa_q * opb_q;
      end
      ivh_pkg::ST_MUL2: begin
        if (load_out) begin
          code_d      = prod_q * opc_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        code_d = code_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ivh_pkg::ST_RUN;
      fwd_q       <= '0;
      rev_q       <= '0;
      coef_q      <= 32'd1;
      par_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fwd_q       <= fwd_d;
      rev_q       <= rev_d;
      coef_q      <= coef_d;
      par_q       <= par_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    opc_q  <= opc_d;
    prod_q <= prod_d;
    code_q <= code_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/id_string_verification_hash_core.sv =====
// id_string_verification_hash_core
//
// Input channel (in_valid_i / in_ready_o): one beat per string byte, first
// byte first. byte_valid_i marks a beat that carries a byte; last_i marks
// the final beat of a string, and id_i is sampled on that beat. A beat with
// last_i set and no byte ends an empty string; a beat with neither is dropped.
// Output channel (out_valid_o / out_ready_i): one 32-bit code per string.
//
// Accepted beats go into a two-entry queue; the back pops one beat per cycle
// while in its run state and updates the hashes, so bytes stream at one per
// cycle outside the final mix. After the last beat the back leaves the run
// state for the final mix (operand build and two 32x32 multiplies in turn)
// and pops nothing until the code is loaded into the output register.
// While the receiver stalls, the code holds in the output register, the
// back waits in its last multiply step, and the queue fills until in_ready_o
// drops.
// Reset clears the queue, the output valid and the hash state (forward and
// reverse hash zero, coefficient product one, byte parity even).

`default_nettype none

module id_string_verification_hash_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         song_byte_i,
  input  wire logic               byte_valid_i,
  input  wire logic               last_i,
  input  wire logic [31:0]        id_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      code_o
);

  ivh_pkg::fifo_stat_t q_stat;
  ivh_pkg::back_stat_t bk_stat;
  ivh_pkg::item_t      push_item, head_item;
  logic                push, pop;

  ivh_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .song_byte_i  (song_byte_i),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .id_i         (id_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .item_o       (push_item)
  );

  ivh_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  ivh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_stat.empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .stat_o      (bk_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_o      (code_o)
  );

  // Queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= ivh_pkg::QCNT_W'(ivh_pkg::QDEPTH))
    else $error("queue count above depth");

  // A full queue blocks the input
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !in_ready_o)
    else $error("input ready while queue full");

  // Back pops only in its run state
  a_pop_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |-> (bk_stat.state == ivh_pkg::ST_RUN))
    else $error("queue pop outside run state");

  // A new code comes only out of the last multiply step
  a_code_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bk_stat.state == ivh_pkg::ST_MUL2))
    else $error("code valid without finishing the mix");

endmodule

`default_nettype wire

// ===== verif/id_string_verification_hash_checker.sv =====
`timescale 1ns / 1ps

module id_string_verification_hash_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         song_byte_i,
  input  logic               byte_valid_i,
  input  logic               last_i,
  input  logic [31:0]        id_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] code_i,
  output int unsigned        fail_cnt_o,
  output int unsigned        pending_o
);

  // Running state of the string in flight
  logic [31:0] fwd_hash;
  logic [31:0] rev_hash;
  logic [31:0] coef_prod;
  logic        odd_index;

  // Codes the block still owes, oldest first
  logic [31:0] owed_codes[$];
  logic [31:0] owed_code;

  // Rearrange the id bytes; an empty top or upper-middle byte borrows an inverted one
  function automatic logic [31:0] id_mix_word(input logic [31:0] id);
    logic [7:0] b0, b1, b2, b3;
    b0 = id[7:0];
    b1 = id[15:8];
    b2 = id[23:16];
    b3 = id[31:24];
    return {b0, (b2 == 8'h00) ? ~b1 : b2, b1, (b3 == 8'h00) ? ~b0 : b3};
  endfunction

  // Final mix: two products, all mod 2^32
  function automatic logic [31:0] verification_code(input logic [31:0] f,
                                                    input logic [31:0] r,
                                                    input logic [31:0] id);
    logic [31:0] m;
    logic [31:0] acc;
    m   = id_mix_word(id);
    acc = (r ^ m) + (f | id);
    acc = acc * (f | m);
    return acc * (r ^ id);
  endfunction

  // Fold one sign-extended byte into both hashes
  task automatic hash_byte(input logic [7:0] b);
    logic [31:0] c;
    c         = {{24{b[7]}}, b};
    fwd_hash  = c + fwd_hash * (odd_index ? 32'd17 : 32'd9);
    rev_hash  = rev_hash + c * coef_prod;
    coef_prod = coef_prod * (odd_index ? 32'd33 : 32'd17);
    odd_index = ~odd_index;
  endtask

  task automatic clear_string();
    fwd_hash  = 32'd0;
    rev_hash  = 32'd0;
    coef_prod = 32'd1;
    odd_index = 1'b0;
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] hash check: %s", $time, what);
    fail_cnt_o++;
  endtask

  // Check the result beat first, then fold in the input beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_string();
      owed_codes.delete();
      fail_cnt_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_codes.size() == 0) begin
          report_mismatch($sformatf("code %h with no string pending", code_i));
        end else begin
          owed_code = owed_codes.pop_front();
          if (code_i !== owed_code)
            report_mismatch($sformatf("code %h, expected %h", code_i, owed_code));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (byte_valid_i) hash_byte(song_byte_i);
        if (last_i) begin
          owed_codes.push_back(verification_code(fwd_hash, rev_hash, id_i));
          clear_string();
        end
      end
    end
    pending_o = owed_codes.size();
  end

endmodule

// ===== verif/id_string_verification_hash_core_tb.sv =====
`timescale 1ns / 1ps

module id_string_verification_hash_core_tb;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [7:0]         song_byte  = 8'h00;
  logic               byte_valid = 1'b0;
  logic               last_flag  = 1'b0;
  logic [31:0]        id_word    = 32'h0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic signed [31:0] code;

  logic               tail_phase = 1'b0;
  int unsigned        sent_items = 0;
  int unsigned        fail_cnt;
  int unsigned        pending;

  always #1 clk = ~clk;

  id_string_verification_hash_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .song_byte_i  (song_byte),
    .byte_valid_i (byte_valid),
    .last_i       (last_flag),
    .id_i         (id_word),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .code_o       (code)
  );

  id_string_verification_hash_checker hash_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .song_byte_i  (song_byte),
    .byte_valid_i (byte_valid),
    .last_i       (last_flag),
    .id_i         (id_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .code_i       (code),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  // Offer one beat, after an optional idle burst, and hold it until taken
  task automatic send_beat(input logic [7:0] b, input logic bv, input logic lst,
                           input logic [31:0] id);
    int gap;
    gap = 0;
    if (!tail_phase && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    song_byte  <= b;
    byte_valid <= bv;
    last_flag  <= lst;
    id_word    <= id;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (bv || lst) sent_items++;
  endtask

  // Favor the sign boundary and zero now and then
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h80;
      2:       return 8'h7F;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Clear the upper id bytes at times to hit the inverted-byte substitution
  function automatic logic [31:0] pick_id();
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(0, 3) == 0) v[23:16] = 8'h00;
    if ($urandom_range(0, 3) == 0) v[31:24] = 8'h00;
    return v;
  endfunction

  // One string: bytes with stray idle beats, ended on the last byte or by an end beat
  task automatic send_string(input int len, input logic sep_end, input logic [31:0] id);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_beat(pick_byte(), 1'b0, 1'b0, $urandom());
      send_beat(pick_byte(), 1'b1, (i == len - 1) && !sep_end, $urandom());
    end
    if (len == 0 || sep_end) send_beat(pick_byte(), 1'b0, 1'b1, id);
  endtask

  // One receiver step: maybe a stall burst, then a ready stretch
  task automatic ready_step();
    int n;
    if (!tail_phase && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      out_ready <= 1'b0;
      repeat (n) @(posedge clk);
    end
    out_ready <= 1'b1;
    n = tail_phase ? 1 : $urandom_range(1, 12);
    repeat (n) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off to back up the queue, then free flow
  initial begin : receiver
    wait (rst_n === 1'b1);
    @(posedge clk);
    repeat (150) ready_step();
    out_ready <= 1'b0;
    repeat (120) @(posedge clk);
    forever ready_step();
  end

  initial begin : stimulus
    int len;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty strings straight after reset
    send_beat(8'h00, 1'b0, 1'b1, 32'h0000_0000);
    send_beat(8'hA5, 1'b0, 1'b1, 32'hFFFF_FFFF);
    // single-byte strings at the byte extremes
    send_beat(8'h00, 1'b1, 1'b1, 32'h0000_0000);
    send_beat(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // idle beat changes nothing
    send_beat(8'h3C, 1'b0, 1'b0, 32'hDEAD_BEEF);
    send_beat(8'h80, 1'b1, 1'b1, 32'h0000_1234);
    // zero byte inside a string, sign boundary bytes
    send_beat(8'h7F, 1'b1, 1'b0, 32'h0);
    send_beat(8'h00, 1'b1, 1'b0, 32'h0);
    send_beat(8'h80, 1'b1, 1'b0, 32'h0);
    send_beat(8'hFF, 1'b1, 1'b0, 32'h0);
    send_beat(8'h01, 1'b1, 1'b1, 32'h00AB_00CD);
    // string closed by a separate end beat, then an empty string
    send_beat(8'h41, 1'b1, 1'b0, 32'h0);
    send_beat(8'h42, 1'b1, 1'b0, 32'h0);
    send_beat(8'h00, 1'b0, 1'b1, 32'h1200_3456);
    send_beat(8'h00, 1'b0, 1'b1, 32'h8000_0001);
    // idle beat in the middle of a string
    send_beat(8'hC3, 1'b1, 1'b0, 32'h0);
    send_beat(8'h11, 1'b0, 1'b0, 32'h0);
    send_beat(8'h5A, 1'b1, 1'b1, 32'hA5A5_5A5A);

    // random strings, mostly short with an occasional long one
    while (sent_items < 1000) begin
      if (sent_items >= 880 && !tail_phase) tail_phase <= 1'b1;
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
      send_string(len, $urandom_range(0, 3) == 0, pick_id());
    end
    in_valid <= 1'b0;

    // drain outstanding codes, then let the pipeline settle
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
